>>> src/lsch_pkg.sv
// ----------------------------------------------------------------------------
// Lottery scheduler package
// Shared types, codes and small helper functions for the lottery scheduler.
// ----------------------------------------------------------------------------
package lsch_pkg;

  localparam int PID_W = 10;
  localparam int TIX_W = 16;
  localparam int DIV_W = 32;

  typedef logic [PID_W-1:0] pid_t;
  typedef logic [TIX_W-1:0] tix_t;

  // Request kinds.
  localparam logic [3:0] K_ENQ   = 4'd0;
  localparam logic [3:0] K_DEQ   = 4'd1;
  localparam logic [3:0] K_SET   = 4'd2;
  localparam logic [3:0] K_ADD   = 4'd3;
  localparam logic [3:0] K_REM   = 4'd4;
  localparam logic [3:0] K_XFER  = 4'd5;
  localparam logic [3:0] K_TICK  = 4'd6;
  localparam logic [3:0] K_YIELD = 4'd7;
  localparam logic [3:0] K_PREEMPT = 4'd8;
  localparam logic [3:0] K_QUERY = 4'd9;

  // Result status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_MISSING = 2'd1;
  localparam logic [1:0] STAT_REFUSED = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_DEFAULT = 3'd0;
  localparam logic [2:0] CFG_MIN     = 3'd1;
  localparam logic [2:0] CFG_MAX     = 3'd2;
  localparam logic [2:0] CFG_QUANTUM = 3'd3;
  localparam logic [2:0] CFG_COMP    = 3'd4;
  localparam logic [2:0] CFG_SEED    = 3'd5;

  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_ADD = 32'd12345;

  typedef struct packed {
    logic [3:0] kind;
    pid_t       pid;
    pid_t       target_pid;
    tix_t       amount;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    tix_t       value;
    logic       switched;
    logic       old_valid;
    pid_t       old_pid;
    logic       running_valid;
    pid_t       running_pid;
    tix_t       quantum_left;
  } out_item_t;

  typedef struct packed {
    pid_t pid;
    tix_t base;
    tix_t comp;
  } ent_t;

  // Current tickets of an entry: base plus compensation, saturated.
  function automatic tix_t cur_tix(input tix_t b, input tix_t c);
    logic [TIX_W:0] s;
    s = {1'b0, b} + {1'b0, c};
    return s[TIX_W] ? {TIX_W{1'b1}} : s[TIX_W-1:0];
  endfunction

  // Lower bound first, then upper bound.
  function automatic tix_t clamp_tix(input logic [TIX_W:0] t, input tix_t lo,
                                     input tix_t hi);
    logic [TIX_W:0] r;
    r = t;
    if (r < {1'b0, lo}) r = {1'b0, lo};
    if (r > {1'b0, hi}) r = {1'b0, hi};
    return r[TIX_W-1:0];
  endfunction

endpackage

>>> src/lsch_ram.sv
// ----------------------------------------------------------------------------
// Lottery scheduler RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module lsch_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/lsch_div.sv
// ----------------------------------------------------------------------------
// Lottery scheduler divider
// Restoring divider, one quotient bit per cycle, shared by draw and yield.
// ----------------------------------------------------------------------------
module lsch_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     go,
  input  logic [lsch_pkg::DIV_W-1:0] dividend,
  input  logic [lsch_pkg::DIV_W-1:0] divisor,
  output logic                     done,
  output logic [lsch_pkg::DIV_W-1:0] quotient,
  output logic [lsch_pkg::DIV_W-1:0] remainder
);
  import lsch_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] rem_r, rem_nxt, quo_r, quo_nxt, dvs_r, dvs_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [DIV_W:0]   trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[DIV_W-1]};
    if (go) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DIV_W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

>>> src/lottery_scheduler_top.sv
// ----------------------------------------------------------------------------
// Lottery scheduler top level
// Participant table, ticket bookkeeping, draws and context switch decisions.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Busy stays high until
// the cycle in which the item's single result appears on out_item. The result
// is shown for exactly one cycle with out_valid high, and busy is already low
// in that cycle. The receiver cannot hold it off, so it must take it in that
// cycle. The table lives in one RAM with a registered read and is walked one
// entry per cycle. Enqueue and dequeue also move the table entry by entry, a
// read and then a write for each, through the same RAM. A draw steps the LCG,
// takes the modulo in the shared restoring divider (a load state, the go, 32
// quotient steps and the state that takes the done), walks the table and then
// decides the switch. A yield with compensation adds a lookup and, while part
// of the quantum is left, a second division. Every item ends in a state that
// registers its result. Writing compensation_on to 0 while idle or during a
// clearing pass starts a new clearing pass with busy high.
// ----------------------------------------------------------------------------
module lottery_scheduler_top #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lsch_pkg::in_item_t  in_item,
  output logic                out_valid,
  output lsch_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import lsch_pkg::*;

  localparam int AW    = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int TOT_W = AW + TIX_W;

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] ST_IDLE  = 5'd0;
  localparam logic [ST_W-1:0] ST_FIND  = 5'd1;
  localparam logic [ST_W-1:0] ST_DISP  = 5'd2;
  localparam logic [ST_W-1:0] ST_SHUP  = 5'd3;
  localparam logic [ST_W-1:0] ST_ENQW  = 5'd4;
  localparam logic [ST_W-1:0] ST_SHDN  = 5'd5;
  localparam logic [ST_W-1:0] ST_XF1   = 5'd6;
  localparam logic [ST_W-1:0] ST_XF2   = 5'd7;
  localparam logic [ST_W-1:0] ST_YMUL  = 5'd8;
  localparam logic [ST_W-1:0] ST_YDIV  = 5'd9;
  localparam logic [ST_W-1:0] ST_YWR   = 5'd10;
  localparam logic [ST_W-1:0] ST_SCHED = 5'd11;
  localparam logic [ST_W-1:0] ST_MODS  = 5'd12;
  localparam logic [ST_W-1:0] ST_MOD   = 5'd13;
  localparam logic [ST_W-1:0] ST_WALK  = 5'd14;
  localparam logic [ST_W-1:0] ST_WIN   = 5'd15;
  localparam logic [ST_W-1:0] ST_SWEEP = 5'd16;
  localparam logic [ST_W-1:0] ST_DONE  = 5'd17;

  // What a lookup is for.
  localparam logic [1:0] FP_ITEM = 2'd0;
  localparam logic [1:0] FP_TGT  = 2'd1;
  localparam logic [1:0] FP_RUN  = 2'd2;

  logic [ST_W-1:0] state_r, state_nxt;

  // Configuration.
  tix_t def_r, min_r, max_r, quant_r;
  logic comp_on_r;

  // Scheduler state.
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic [31:0]      lcg_r, lcg_nxt;
  logic             run_valid_r, run_valid_nxt;
  pid_t             run_pid_r, run_pid_nxt;
  tix_t             ticks_r, ticks_nxt;

  // Per-item working registers.
  in_item_t         item_r, item_nxt;
  logic [1:0]       fph_r, fph_nxt;
  pid_t             key_r, key_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt, sh_r, sh_nxt;
  logic [AW-1:0]    rpos_r, rpos_nxt;
  logic             rv_r, rv_nxt, ph_r, ph_nxt;
  logic             found_r, found_nxt, found2_r, found2_nxt;
  logic [AW-1:0]    pos_r, pos_nxt, pos2_r, pos2_nxt;
  ent_t             ent_r, ent_nxt, ent2_r, ent2_nxt;
  tix_t             xt_r, xt_nxt;
  logic [TOT_W-1:0] acc_r, acc_nxt;
  logic [14:0]      draw_r, draw_nxt;
  pid_t             defwin_r, defwin_nxt, win_r, win_nxt;

  // Result fields.
  logic [1:0] status_r, status_nxt;
  tix_t       value_r, value_nxt;
  logic       sw_r, sw_nxt, oldv_r, oldv_nxt;
  pid_t       oldpid_r, oldpid_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r, out_nxt;

  // Table RAM and divider.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  ent_t          ram_wdata, ram_rdata;
  logic [$bits(ent_t)-1:0] ram_rdata_raw;

  logic             div_go_r, div_go_nxt, div_done;
  logic [DIV_W-1:0] div_a_r, div_a_nxt, div_b_r, div_b_nxt, div_q, div_rem;

  lsch_ram #(
    .WIDTH($bits(ent_t)),
    .DEPTH(MAX_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata_raw)
  );
  assign ram_rdata = ent_t'(ram_rdata_raw);

  lsch_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go_r),
    .dividend (div_a_r),
    .divisor  (div_b_r),
    .done     (div_done),
    .quotient (div_q),
    .remainder(div_rem)
  );

  function automatic logic [TOT_W-1:0] tw(input tix_t x);
    return {{(TOT_W-TIX_W){1'b0}}, x};
  endfunction

  always_comb begin
    tix_t           nb;
    tix_t           avail, room, t1;
    tix_t           nfs, nts;
    logic [TIX_W:0] sum17;
    logic [TOT_W-1:0] accn;

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    total_nxt     = total_r;
    lcg_nxt       = lcg_r;
    run_valid_nxt = run_valid_r;
    run_pid_nxt   = run_pid_r;
    ticks_nxt     = ticks_r;
    item_nxt      = item_r;
    fph_nxt       = fph_r;
    key_nxt       = key_r;
    scan_nxt      = scan_r;
    sh_nxt        = sh_r;
    rpos_nxt      = rpos_r;
    rv_nxt        = 1'b0;
    ph_nxt        = ph_r;
    found_nxt     = found_r;
    found2_nxt    = found2_r;
    pos_nxt       = pos_r;
    pos2_nxt      = pos2_r;
    ent_nxt       = ent_r;
    ent2_nxt      = ent2_r;
    xt_nxt        = xt_r;
    acc_nxt       = acc_r;
    draw_nxt      = draw_r;
    defwin_nxt    = defwin_r;
    win_nxt       = win_r;
    status_nxt    = status_r;
    value_nxt     = value_r;
    sw_nxt        = sw_r;
    oldv_nxt      = oldv_r;
    oldpid_nxt    = oldpid_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    div_go_nxt    = 1'b0;
    div_a_nxt     = div_a_r;
    div_b_nxt     = div_b_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = ent_r;
    ram_raddr     = '0;
    nb            = '0;
    avail         = '0;
    room          = '0;
    t1            = '0;
    nfs           = '0;
    nts           = '0;
    sum17         = '0;
    accn          = acc_r + tw(cur_tix(ram_rdata.base, ram_rdata.comp));

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_nxt   = in_item;
          key_nxt    = in_item.pid;
          fph_nxt    = FP_ITEM;
          scan_nxt   = '0;
          found_nxt  = 1'b0;
          found2_nxt = 1'b0;
          status_nxt = STAT_OK;
          value_nxt  = '0;
          sw_nxt     = 1'b0;
          oldv_nxt   = 1'b0;
          oldpid_nxt = '0;
          case (in_item.kind) inside
            K_ENQ, K_DEQ, K_SET, K_ADD, K_REM, K_XFER, K_QUERY: begin
              state_nxt = ST_FIND;
            end
            K_TICK: begin
              if (ticks_r != '0) ticks_nxt = ticks_r - 1'b1;
              if (ticks_r <= TIX_W'(1)) state_nxt = ST_SCHED;
              else state_nxt = ST_DONE;
            end
            K_YIELD: begin
              if (run_valid_r && comp_on_r) begin
                key_nxt   = run_pid_r;
                fph_nxt   = FP_RUN;
                state_nxt = ST_FIND;
              end else begin
                ticks_nxt = '0;
                state_nxt = ST_SCHED;
              end
            end
            K_PREEMPT: begin
              ticks_nxt = '0;
              state_nxt = ST_SCHED;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end

      // Walk the table in order, one read issued per cycle.
      ST_FIND: begin
        if (rv_r && ram_rdata.pid == key_r) begin
          if (fph_r == FP_TGT) begin
            found2_nxt = 1'b1;
            pos2_nxt   = rpos_r;
            ent2_nxt   = ram_rdata;
          end else begin
            found_nxt = 1'b1;
            pos_nxt   = rpos_r;
            ent_nxt   = ram_rdata;
          end
          state_nxt = ST_DISP;
        end else if (scan_r == cnt_r) begin
          state_nxt = ST_DISP;
        end else begin
          ram_raddr = scan_r[AW-1:0];
          rpos_nxt  = scan_r[AW-1:0];
          rv_nxt    = 1'b1;
          scan_nxt  = scan_r + 1'b1;
        end
      end

      ST_DISP: begin
        state_nxt = ST_DONE;
        if (fph_r == FP_RUN) begin
          if (found_r) begin
            if (ticks_r != '0 && ticks_r < quant_r) begin
              state_nxt = ST_YMUL;
            end else begin
              xt_nxt    = '0;
              state_nxt = ST_YWR;
            end
          end else begin
            ticks_nxt = '0;
            state_nxt = ST_SCHED;
          end
        end else if (fph_r == FP_TGT) begin
          if (!found2_r) begin
            status_nxt = STAT_MISSING;
          end else begin
            avail = (ent_r.base > min_r) ? ent_r.base - min_r : '0;
            t1    = (item_r.amount < avail) ? item_r.amount : avail;
            room  = (max_r > ent2_r.base) ? max_r - ent2_r.base : '0;
            if (t1 != '0) begin
              xt_nxt    = (t1 > room) ? room : t1;
              value_nxt = (t1 > room) ? room : t1;
              state_nxt = ST_XF1;
            end
          end
        end else if (item_r.kind == K_ENQ) begin
          if (found_r || cnt_r == CNT_W'(MAX_ENTRIES)) begin
            status_nxt = STAT_REFUSED;
          end else if (cnt_r == '0) begin
            state_nxt = ST_ENQW;
          end else begin
            sh_nxt    = cnt_r;
            ph_nxt    = 1'b0;
            state_nxt = ST_SHUP;
          end
        end else if (!found_r) begin
          status_nxt = STAT_MISSING;
        end else begin
          case (item_r.kind) inside
            K_DEQ: begin
              total_nxt = total_r - tw(cur_tix(ent_r.base, ent_r.comp));
              if (run_valid_r && run_pid_r == item_r.pid) begin
                run_valid_nxt = 1'b0;
                run_pid_nxt   = '0;
                ticks_nxt     = '0;
              end
              sh_nxt    = {{(CNT_W-AW){1'b0}}, pos_r};
              ph_nxt    = 1'b0;
              state_nxt = ST_SHDN;
            end
            K_SET, K_ADD, K_REM: begin
              if (item_r.kind == K_SET) begin
                sum17 = {1'b0, item_r.amount};
              end else if (item_r.kind == K_ADD) begin
                sum17 = {1'b0, ent_r.base} + {1'b0, item_r.amount};
                if (sum17 > {1'b0, max_r}) sum17 = {1'b0, max_r};
              end else begin
                sum17 = (item_r.amount >= ent_r.base) ? {1'b0, min_r}
                                                     : {1'b0, ent_r.base - item_r.amount};
              end
              nb        = clamp_tix(sum17, min_r, max_r);
              value_nxt = ent_r.base;
              ram_we    = 1'b1;
              ram_waddr = pos_r;
              ram_wdata = '{pid: ent_r.pid, base: nb, comp: ent_r.comp};
              total_nxt = total_r - tw(cur_tix(ent_r.base, ent_r.comp))
                          + tw(cur_tix(nb, ent_r.comp));
            end
            K_XFER: begin
              key_nxt   = item_r.target_pid;
              fph_nxt   = FP_TGT;
              scan_nxt  = '0;
              state_nxt = ST_FIND;
            end
            K_QUERY: value_nxt = cur_tix(ent_r.base, ent_r.comp);
            default: ;
          endcase
        end
      end

      // Open position zero by moving every member down by one.
      ST_SHUP: begin
        if (!ph_r) begin
          ram_raddr = AW'(sh_r - 1'b1);
          ph_nxt    = 1'b1;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = sh_r[AW-1:0];
          ram_wdata = ram_rdata;
          sh_nxt    = sh_r - 1'b1;
          ph_nxt    = 1'b0;
          if (sh_r == CNT_W'(1)) state_nxt = ST_ENQW;
        end
      end

      ST_ENQW: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '{pid: item_r.pid, base: def_r, comp: '0};
        cnt_nxt   = cnt_r + 1'b1;
        total_nxt = total_r + tw(def_r);
        state_nxt = ST_DONE;
      end

      // Close the gap left by the removed member.
      ST_SHDN: begin
        if (sh_r + 1'b1 >= cnt_r) begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = ST_DONE;
        end else if (!ph_r) begin
          ram_raddr = AW'(sh_r + 1'b1);
          ph_nxt    = 1'b1;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = sh_r[AW-1:0];
          ram_wdata = ram_rdata;
          sh_nxt    = sh_r + 1'b1;
          ph_nxt    = 1'b0;
        end
      end

      ST_XF1: begin
        nfs       = clamp_tix({1'b0, ent_r.base - xt_r}, min_r, max_r);
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = '{pid: ent_r.pid, base: nfs, comp: ent_r.comp};
        total_nxt = total_r - tw(cur_tix(ent_r.base, ent_r.comp))
                    + tw(cur_tix(nfs, ent_r.comp));
        if (pos2_r == pos_r) ent2_nxt.base = nfs;
        state_nxt = ST_XF2;
      end

      ST_XF2: begin
        nts       = clamp_tix({1'b0, ent2_r.base} + {1'b0, xt_r}, min_r, max_r);
        ram_we    = 1'b1;
        ram_waddr = pos2_r;
        ram_wdata = '{pid: ent2_r.pid, base: nts, comp: ent2_r.comp};
        total_nxt = total_r - tw(cur_tix(ent2_r.base, ent2_r.comp))
                    + tw(cur_tix(nts, ent2_r.comp));
        state_nxt = ST_DONE;
      end

      // Compensation: base * left / (quantum - left).
      ST_YMUL: begin
        div_a_nxt  = DIV_W'(ent_r.base * ticks_r);
        div_b_nxt  = DIV_W'(quant_r - ticks_r);
        div_go_nxt = 1'b1;
        state_nxt  = ST_YDIV;
      end

      ST_YDIV: begin
        if (div_done) begin
          xt_nxt    = (div_q > DIV_W'({TIX_W{1'b1}})) ? {TIX_W{1'b1}} : div_q[TIX_W-1:0];
          state_nxt = ST_YWR;
        end
      end

      ST_YWR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = '{pid: ent_r.pid, base: ent_r.base, comp: xt_r};
        total_nxt = total_r - tw(cur_tix(ent_r.base, ent_r.comp))
                    + tw(cur_tix(ent_r.base, xt_r));
        ticks_nxt = '0;
        state_nxt = ST_SCHED;
      end

      ST_SCHED: begin
        if (cnt_r == '0 || total_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          lcg_nxt   = lcg_r * LCG_MUL + LCG_ADD;
          state_nxt = ST_MODS;
        end
      end

      ST_MODS: begin
        div_a_nxt  = {{(DIV_W-15){1'b0}}, lcg_r[30:16]};
        div_b_nxt  = DIV_W'(total_r);
        div_go_nxt = 1'b1;
        state_nxt  = ST_MOD;
      end

      ST_MOD: begin
        if (div_done) begin
          draw_nxt  = div_rem[14:0];
          scan_nxt  = '0;
          acc_nxt   = '0;
          defwin_nxt = '0;
          state_nxt = ST_WALK;
        end
      end

      // Running sum over the table; first entry whose sum passes the draw wins.
      ST_WALK: begin
        if (rv_r) begin
          acc_nxt = accn;
          if (rpos_r == '0) defwin_nxt = ram_rdata.pid;
        end
        if (rv_r && accn > TOT_W'(draw_r)) begin
          win_nxt   = ram_rdata.pid;
          state_nxt = ST_WIN;
        end else if (scan_r == cnt_r) begin
          win_nxt   = (rv_r && rpos_r == '0) ? ram_rdata.pid : defwin_r;
          state_nxt = ST_WIN;
        end else begin
          ram_raddr = scan_r[AW-1:0];
          rpos_nxt  = scan_r[AW-1:0];
          rv_nxt    = 1'b1;
          scan_nxt  = scan_r + 1'b1;
        end
      end

      ST_WIN: begin
        if (!run_valid_r || win_r != run_pid_r) begin
          sw_nxt        = 1'b1;
          oldv_nxt      = run_valid_r;
          oldpid_nxt    = run_valid_r ? run_pid_r : '0;
          run_valid_nxt = 1'b1;
          run_pid_nxt   = win_r;
        end
        ticks_nxt = quant_r;
        state_nxt = ST_DONE;
      end

      // Clear every member's compensation and rebuild the total from bases.
      ST_SWEEP: begin
        if (rv_r) begin
          ram_we    = 1'b1;
          ram_waddr = rpos_r;
          ram_wdata = '{pid: ram_rdata.pid, base: ram_rdata.base, comp: '0};
          total_nxt = total_r + tw(ram_rdata.base);
        end
        if (scan_r == cnt_r) begin
          state_nxt = ST_IDLE;
        end else begin
          ram_raddr = scan_r[AW-1:0];
          rpos_nxt  = scan_r[AW-1:0];
          rv_nxt    = 1'b1;
          scan_nxt  = scan_r + 1'b1;
        end
      end

      ST_DONE: begin
        out_valid_nxt         = 1'b1;
        out_nxt.status        = status_r;
        out_nxt.value         = value_r;
        out_nxt.switched      = sw_r;
        out_nxt.old_valid     = oldv_r;
        out_nxt.old_pid       = oldpid_r;
        out_nxt.running_valid = run_valid_r;
        out_nxt.running_pid   = run_valid_r ? run_pid_r : '0;
        out_nxt.quantum_left  = ticks_r;
        state_nxt             = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase

    // Turning compensation off while idle or sweeping starts (or restarts) the clearing pass.
    if (cfg_we && cfg_index == CFG_COMP && !cfg_data[0] &&
        (state_r == ST_IDLE || state_r == ST_SWEEP)) begin
      state_nxt = ST_SWEEP;
      scan_nxt  = '0;
      rv_nxt    = 1'b0;
      total_nxt = '0;
      ram_we    = 1'b0;
    end
    if (cfg_we && cfg_index == CFG_SEED) begin
      lcg_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      def_r       <= 16'd100;
      min_r       <= 16'd1;
      max_r       <= 16'd10000;
      quant_r     <= 16'd10;
      comp_on_r   <= 1'b1;
      cnt_r       <= '0;
      total_r     <= '0;
      lcg_r       <= 32'd1;
      run_valid_r <= 1'b0;
      run_pid_r   <= '0;
      ticks_r     <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      total_r     <= total_nxt;
      lcg_r       <= lcg_nxt;
      run_valid_r <= run_valid_nxt;
      run_pid_r   <= run_pid_nxt;
      ticks_r     <= ticks_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
      div_go_r    <= div_go_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DEFAULT: def_r     <= cfg_data[TIX_W-1:0];
          CFG_MIN:     min_r     <= cfg_data[TIX_W-1:0];
          CFG_MAX:     max_r     <= cfg_data[TIX_W-1:0];
          CFG_QUANTUM: quant_r   <= cfg_data[TIX_W-1:0];
          CFG_COMP:    comp_on_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
    item_r   <= item_nxt;
    fph_r    <= fph_nxt;
    key_r    <= key_nxt;
    scan_r   <= scan_nxt;
    sh_r     <= sh_nxt;
    rpos_r   <= rpos_nxt;
    ph_r     <= ph_nxt;
    found_r  <= found_nxt;
    found2_r <= found2_nxt;
    pos_r    <= pos_nxt;
    pos2_r   <= pos2_nxt;
    ent_r    <= ent_nxt;
    ent2_r   <= ent2_nxt;
    xt_r     <= xt_nxt;
    acc_r    <= acc_nxt;
    draw_r   <= draw_nxt;
    defwin_r <= defwin_nxt;
    win_r    <= win_nxt;
    status_r <= status_nxt;
    value_r  <= value_nxt;
    sw_r     <= sw_nxt;
    oldv_r   <= oldv_nxt;
    oldpid_r <= oldpid_nxt;
    out_r    <= out_nxt;
    div_a_r  <= div_a_nxt;
    div_b_r  <= div_b_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

>>> src/lsch_checker.sv
// ----------------------------------------------------------------------------
// Lottery scheduler checker
// Port-level assertions on the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module lsch_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input lsch_pkg::out_item_t out_item
);

  // An accepted item always makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("item accepted without going busy");

  // Results are single-cycle strobes shown once the block is free again.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy ##1 !out_valid)
    else $error("result strobe overlaps work or lasts two cycles");

  // A switch always lands on a running process different from the old one.
  a_switch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.switched |-> out_item.running_valid &&
      (!out_item.old_valid || out_item.old_pid != out_item.running_pid))
    else $error("inconsistent context switch");

  // With nothing running there is neither a pid nor a quantum.
  a_idle_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.running_valid |->
      out_item.running_pid == '0 && out_item.quantum_left == '0)
    else $error("stale running state");

endmodule

bind lottery_scheduler_top lsch_checker u_lsch_checker (.*);

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lottery scheduler testbench
// Drives directed and random scheduler requests through the command port,
// keeps its own model of the participant table, ticket total, random draw and
// running process, and checks every result field by field against it. The
// run steps through several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb;
  import lsch_pkg::*;

  localparam int SLOTS = 256;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_DEFAULT;
  logic [31:0] cfg_data = '0;

  lottery_scheduler_top #(.MAX_ENTRIES(SLOTS)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Requests waiting to be sent, and the results we expect back, oldest first.
  in_item_t  pending_reqs[$];
  out_item_t expected_results[$];
  int        errors = 0;
  int        gap_pct = 18;

  // Our own copy of the scheduler state and its registers.
  logic [9:0]  m_pid [SLOTS];
  logic [15:0] m_base[SLOTS];
  logic [15:0] m_comp[SLOTS];
  logic [7:0]  m_order[SLOTS];
  int          m_count;
  logic [31:0] m_total;
  logic [31:0] m_lcg;
  logic        m_run;
  logic [9:0]  m_run_pid;
  logic [15:0] m_left;
  logic [15:0] r_default, r_min, r_max, r_quantum;
  logic        r_comp;

  // Current tickets of a slot: base plus compensation, saturated at 16 bits.
  function automatic logic [15:0] tickets_now(int s);
    logic [16:0] sum;
    sum = {1'b0, m_base[s]} + {1'b0, m_comp[s]};
    return sum[16] ? 16'hFFFF : sum[15:0];
  endfunction

  // Table position of a pid, or -1 when it is not a member.
  function automatic int table_pos(logic [9:0] p);
    for (int i = 0; i < m_count; i++)
      if (m_pid[m_order[i]] == p) return i;
    return -1;
  endfunction

  task automatic set_base(int s, logic [15:0] b);
    m_total = m_total - 32'(tickets_now(s));
    m_base[s] = b;
    m_total = m_total + 32'(tickets_now(s));
  endtask

  task automatic set_comp(int s, logic [15:0] c);
    m_total = m_total - 32'(tickets_now(s));
    m_comp[s] = c;
    m_total = m_total + 32'(tickets_now(s));
  endtask

  // Applies the min bound first, then the max bound; returns the old base.
  task automatic clamp_base(int s, logic [16:0] t, output logic [15:0] old);
    old = m_base[s];
    if (t < {1'b0, r_min}) t = {1'b0, r_min};
    if (t > {1'b0, r_max}) t = {1'b0, r_max};
    set_base(s, t[15:0]);
  endtask

  // Lottery draw: keeps a process that still has quantum, else picks a winner.
  task automatic run_lottery(inout out_item_t r);
    logic [31:0] draw, acc;
    logic [9:0]  winner;
    bit          found;
    if (m_run && m_left != 0 && table_pos(m_run_pid) >= 0) return;
    if (m_count == 0 || m_total == 0) return;
    m_lcg = m_lcg * LCG_MUL + LCG_ADD;
    draw = {17'd0, m_lcg[30:16]} % m_total;
    winner = m_pid[m_order[0]];
    acc = 0;
    found = 0;
    for (int i = 0; i < m_count && !found; i++) begin
      acc = acc + 32'(tickets_now(m_order[i]));
      if (acc > draw) begin
        winner = m_pid[m_order[i]];
        found = 1;
      end
    end
    if (!m_run || winner != m_run_pid) begin
      r.switched = 1'b1;
      r.old_valid = m_run;
      r.old_pid = m_run ? m_run_pid : 10'd0;
      m_run = 1'b1;
      m_run_pid = winner;
    end
    m_left = r_quantum;
  endtask

  // Works out the result of one accepted request and updates the model.
  task automatic predict_request(in_item_t it, output out_item_t r);
    int          pos, pos2, s, fs, ts;
    logic [16:0] nb;
    logic [15:0] old, avail, room, t;
    logic [63:0] c;
    r = '0;
    pos = (it.kind <= K_XFER || it.kind == K_QUERY) ? table_pos(it.pid) : -1;
    case (it.kind)
      K_ENQ: begin
        if (pos >= 0 || m_count >= SLOTS) begin
          r.status = STAT_REFUSED;
        end else begin
          s = m_order[m_count];
          for (int i = m_count; i > 0; i--) m_order[i] = m_order[i-1];
          m_order[0] = s[7:0];
          m_pid[s] = it.pid;
          m_base[s] = r_default;
          m_comp[s] = '0;
          m_count++;
          m_total = m_total + 32'(tickets_now(s));
        end
      end
      K_DEQ: begin
        if (pos < 0) begin
          r.status = STAT_MISSING;
        end else begin
          s = m_order[pos];
          m_total = m_total - 32'(tickets_now(s));
          for (int i = pos; i + 1 < m_count; i++) m_order[i] = m_order[i+1];
          m_count--;
          m_order[m_count] = s[7:0];
          if (m_run && m_run_pid == it.pid) begin
            m_run = 1'b0;
            m_run_pid = '0;
            m_left = '0;
          end
        end
      end
      K_SET, K_ADD, K_REM: begin
        if (pos < 0) begin
          r.status = STAT_MISSING;
        end else begin
          s = m_order[pos];
          if (it.kind == K_SET) begin
            nb = {1'b0, it.amount};
          end else if (it.kind == K_ADD) begin
            nb = {1'b0, m_base[s]} + {1'b0, it.amount};
            if (nb > {1'b0, r_max}) nb = {1'b0, r_max};
          end else begin
            nb = (it.amount >= m_base[s]) ? {1'b0, r_min} : {1'b0, m_base[s] - it.amount};
          end
          clamp_base(s, nb, old);
          r.value = old;
        end
      end
      K_XFER: begin
        pos2 = table_pos(it.target_pid);
        if (pos < 0 || pos2 < 0) begin
          r.status = STAT_MISSING;
        end else begin
          fs = m_order[pos];
          ts = m_order[pos2];
          avail = (m_base[fs] > r_min) ? m_base[fs] - r_min : 16'd0;
          t = (it.amount < avail) ? it.amount : avail;
          if (t != 0) begin
            room = (r_max > m_base[ts]) ? r_max - m_base[ts] : 16'd0;
            if (t > room) t = room;
            clamp_base(fs, {1'b0, m_base[fs] - t}, old);
            // The target base is read again, since source and target may match.
            clamp_base(ts, {1'b0, m_base[ts]} + {1'b0, t}, old);
            r.value = t;
          end
        end
      end
      K_TICK: begin
        if (m_left != 0) m_left--;
        if (m_left == 0) run_lottery(r);
      end
      K_YIELD: begin
        if (m_run && r_comp) begin
          pos2 = table_pos(m_run_pid);
          if (pos2 >= 0) begin
            s = m_order[pos2];
            c = '0;
            if (m_left != 0 && m_left < r_quantum) begin
              c = (64'(m_base[s]) * 64'(m_left)) / 64'(r_quantum - m_left);
              if (c > 64'hFFFF) c = 64'hFFFF;
            end
            set_comp(s, c[15:0]);
          end
        end
        m_left = '0;
        run_lottery(r);
      end
      K_PREEMPT: begin
        m_left = '0;
        run_lottery(r);
      end
      K_QUERY: begin
        if (pos < 0) r.status = STAT_MISSING;
        else r.value = tickets_now(m_order[pos]);
      end
      default: ;
    endcase
    r.running_valid = m_run;
    r.running_pid = m_run ? m_run_pid : 10'd0;
    r.quantum_left = m_left;
  endtask

  task automatic check_field(input string nm, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, nm, e, a);
      errors++;
    end
  endtask

  // Result checking first, then request acceptance; both on the rising edge.
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst_n && out_valid) begin
      got = out_item;
      if (expected_results.size() == 0) begin
        $display("%0t ns: result with none expected, got %h", $time, got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("value", 32'(want.value), 32'(got.value));
        check_field("switched", 32'(want.switched), 32'(got.switched));
        check_field("old_valid", 32'(want.old_valid), 32'(got.old_valid));
        check_field("old_pid", 32'(want.old_pid), 32'(got.old_pid));
        check_field("running_valid", 32'(want.running_valid),
                    32'(got.running_valid));
        check_field("running_pid", 32'(want.running_pid), 32'(got.running_pid));
        check_field("quantum_left", 32'(want.quantum_left),
                    32'(got.quantum_left));
      end
    end
    if (rst_n && start && !busy) begin
      predict_request(in_item, want);
      expected_results.push_back(want);
      void'(pending_reqs.pop_front());
    end
  end

  // Request driver: offers the oldest pending item, idling at random.
  always @(negedge clk) begin
    if (rst_n && pending_reqs.size() != 0 && $urandom_range(99) >= gap_pct) begin
      start <= 1'b1;
      in_item <= pending_reqs[0];
    end else begin
      start <= 1'b0;
    end
  end

  function automatic logic [9:0] rand_pid();
    // Mostly a small pool so that lookups hit; sometimes the full pid range.
    return ($urandom_range(99) < 88) ? 10'($urandom_range(15)) : 10'($urandom_range(1023));
  endfunction

  function automatic logic [15:0] rand_amount();
    int r;
    r = $urandom_range(99);
    if (r < 30) return 16'($urandom_range(200));
    if (r < 45) return 16'd0;
    if (r < 55) return 16'hFFFF;
    if (r < 70) return 16'($urandom_range(20000));
    return 16'($urandom);
  endfunction

  function automatic in_item_t rand_request();
    in_item_t it;
    int r;
    r = $urandom_range(99);
    if      (r < 14) it.kind = K_ENQ;
    else if (r < 22) it.kind = K_DEQ;
    else if (r < 30) it.kind = K_SET;
    else if (r < 37) it.kind = K_ADD;
    else if (r < 44) it.kind = K_REM;
    else if (r < 52) it.kind = K_XFER;
    else if (r < 74) it.kind = K_TICK;
    else if (r < 84) it.kind = K_YIELD;
    else if (r < 90) it.kind = K_PREEMPT;
    else if (r < 97) it.kind = K_QUERY;
    else             it.kind = 4'($urandom_range(10, 15));
    it.pid = rand_pid();
    it.target_pid = rand_pid();
    it.amount = rand_amount();
    return it;
  endfunction

  task automatic push_req(logic [3:0] k, logic [9:0] p, logic [9:0] tp, logic [15:0] a);
    in_item_t it;
    it.kind = k;
    it.pid = p;
    it.target_pid = tp;
    it.amount = a;
    pending_reqs.push_back(it);
  endtask

  task automatic push_random(int n);
    repeat (n) pending_reqs.push_back(rand_request());
  endtask

  // Waits until every request has been sent and answered, then lets the block
  // settle before anything touches its registers.
  task automatic drain();
    while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (20) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  // Register write; the model takes the same value. Clearing compensation
  // keeps the block busy for a table pass, so we wait for it to finish.
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_DEFAULT: r_default = data[15:0];
      CFG_MIN:     r_min = data[15:0];
      CFG_MAX:     r_max = data[15:0];
      CFG_QUANTUM: r_quantum = data[15:0];
      CFG_COMP: begin
        r_comp = data[0];
        if (!r_comp)
          for (int i = 0; i < m_count; i++) set_comp(int'(m_order[i]), '0);
      end
      CFG_SEED:    m_lcg = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      m_pid[i] = '0;
      m_base[i] = '0;
      m_comp[i] = '0;
      m_order[i] = 8'(i);
    end
    m_count = 0;
    m_total = '0;
    m_lcg = 32'd1;
    m_run = 1'b0;
    m_run_pid = '0;
    m_left = '0;
    r_default = 16'd100;
    r_min = 16'd1;
    r_max = 16'd10000;
    r_quantum = 16'd10;
    r_comp = 1'b1;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part with reset register values: a draw from an empty pool,
    // duplicates, missing processes, clamping at both ends, transfers
    // including one to itself, yield compensation and unknown kinds.
    gap_pct = 18;
    push_req(K_TICK,    10'd0,    10'd0,    16'd0);
    push_req(K_ENQ,     10'd0,    10'd1023, 16'hFFFF);
    push_req(K_ENQ,     10'd1023, 10'd0,    16'd0);
    push_req(K_ENQ,     10'd0,    10'd0,    16'd0);
    push_req(K_QUERY,   10'd0,    10'd0,    16'd0);
    push_req(K_QUERY,   10'd5,    10'd0,    16'd0);
    push_req(K_DEQ,     10'd5,    10'd0,    16'd0);
    push_req(K_SET,     10'd1023, 10'd0,    16'hFFFF);
    push_req(K_SET,     10'd0,    10'd0,    16'd0);
    push_req(K_ADD,     10'd0,    10'd0,    16'hFFFF);
    push_req(K_REM,     10'd0,    10'd0,    16'hFFFF);
    push_req(K_REM,     10'd1023, 10'd0,    16'd1);
    push_req(K_XFER,    10'd1023, 10'd0,    16'd5000);
    push_req(K_XFER,    10'd0,    10'd7,    16'd10);
    push_req(K_XFER,    10'd0,    10'd0,    16'd100);
    push_req(K_XFER,    10'd0,    10'd1023, 16'd0);
    push_req(K_TICK,    10'd0,    10'd0,    16'd0);
    push_req(K_TICK,    10'd0,    10'd0,    16'd0);
    push_req(K_TICK,    10'd0,    10'd0,    16'd0);
    push_req(K_YIELD,   10'd0,    10'd0,    16'd0);
    push_req(K_QUERY,   10'd1023, 10'd0,    16'd0);
    push_req(K_PREEMPT, 10'd0,    10'd0,    16'd0);
    push_req(4'd10,     10'd3,    10'd3,    16'd3);
    push_req(4'd15,     10'd1023, 10'd1023, 16'hFFFF);
    push_random(225);
    drain();

    // Widest ticket range, a short quantum so yields earn saturating
    // compensation, and a table filled past its capacity.
    gap_pct = 56;
    write_reg(CFG_DEFAULT, 32'd65535);
    write_reg(CFG_MIN, 32'd1);
    write_reg(CFG_MAX, 32'd65535);
    write_reg(CFG_QUANTUM, 32'd3);
    write_reg(CFG_SEED, $urandom);
    push_random(150);
    for (int i = 16; i < 16 + SLOTS + 4; i++) push_req(K_ENQ, 10'(i), 10'd0, 16'd0);
    drain();

    // Minimum above maximum, the longest quantum and compensation switched
    // off. Halfway through, the sender waits until everything is answered.
    gap_pct = 0;
    write_reg(CFG_COMP, 32'd0);
    write_reg(CFG_DEFAULT, 32'd1);
    write_reg(CFG_MIN, 32'd65535);
    write_reg(CFG_MAX, 32'd1);
    write_reg(CFG_QUANTUM, 32'd65535);
    write_reg(CFG_SEED, 32'd0);
    push_random(100);
    drain();
    push_random(100);
    drain();

    // Compensation back on, a one-tick quantum and random ticket settings.
    write_reg(CFG_COMP, 32'd1);
    write_reg(CFG_MIN, 32'($urandom_range(1, 50)));
    write_reg(CFG_MAX, 32'($urandom_range(100, 65535)));
    write_reg(CFG_DEFAULT, 32'($urandom_range(1, 65535)));
    write_reg(CFG_QUANTUM, 32'd1);
    write_reg(CFG_SEED, 32'hFFFFFFFF);
    push_random(100);
    drain();
    write_reg(CFG_QUANTUM, 32'($urandom_range(2, 20)));
    push_random(100);
    drain();

    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard limit well beyond the slowest legal run.
  initial begin
    #200_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
